// ----- rtl/ir_manchester_frame_transmitter_defines.svh -----
// Assertion macros for the IR frame transmitter.
`ifndef IR_MANCHESTER_FRAME_TRANSMITTER_DEFINES_SVH
`define IR_MANCHESTER_FRAME_TRANSMITTER_DEFINES_SVH

`ifndef SYNTH

`define IMTX_ASSERT_IMPLY(label, clk, rst, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error("imtx check failed");

`define IMTX_ASSERT_NEXT(label, clk, rst, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error("imtx check failed");

`else

`define IMTX_ASSERT_IMPLY(label, clk, rst, cond, expr)

`define IMTX_ASSERT_NEXT(label, clk, rst, cond, expr)

`endif

`endif

// ----- rtl/imtx_pkg.sv -----
package imtx_pkg;

  localparam int DATA_WIDTH_DEFAULT = 16;

  localparam int CFG_DATA_W  = 5;
  localparam int CFG_INDEX_W = 1;
  localparam int BC_W        = 5;
  localparam int PHASE_W     = 2;
  // wide enough to compare bit counts against any DATA_WIDTH up to 32
  localparam int CMP_W       = 7;

  localparam logic [CFG_INDEX_W-1:0] REG_LEADER_BLOCKS = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_DATA_LENGTH   = 1'd1;

  localparam logic [CFG_DATA_W-1:0] LEADER_RESET = 5'd5;
  localparam logic [CFG_DATA_W-1:0] DLEN_RESET   = 5'd16;
  localparam logic [CFG_DATA_W-1:0] LEADER_MAX   = 5'd30;

  localparam logic [BC_W-1:0] PARITY_HALF = 5'd2;
  localparam logic [BC_W-1:0] PARITY_END  = 5'd4;

  localparam logic [PHASE_W-1:0] PH_LEADER = 2'd0;
  localparam logic [PHASE_W-1:0] PH_START  = 2'd1;
  localparam logic [PHASE_W-1:0] PH_DATA   = 2'd2;
  localparam logic [PHASE_W-1:0] PH_PARITY = 2'd3;

  // floor(x/3) for x < 32: (x * 11) >> 5 is exact over that range
  function automatic logic [3:0] div3(input logic [4:0] x);
    logic [9:0] prod;
    prod = {5'd0, x} * 10'd11;
    return prod[8:5];
  endfunction

endpackage

// ----- rtl/ir_manchester_frame_transmitter.sv -----
// Channel  Direction  Handshake            Payload
// in       input      in_valid / in_ready  action, data_word
// out      output     out_valid/out_ready  carrier_on, busy_res, accepted, frame_done
// cfg      input      cfg_we               cfg_index, cfg_data
//
// One request per cycle: every request is evaluated in the cycle it is accepted
// and its result appears in the output register on the next edge.
// in_ready is high while the output register is empty or being drained.
// A stall on the output side holds the result and blocks new requests.
// rst (synchronous) idles the transmitter with the carrier off and restores
// leader_blocks = 5, data_length = 16.
`include "ir_manchester_frame_transmitter_defines.svh"

module ir_manchester_frame_transmitter #(
  parameter int DATA_WIDTH = imtx_pkg::DATA_WIDTH_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             action,
  input  logic [DATA_WIDTH-1:0]            data_word,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             carrier_on,
  output logic                             busy_res,
  output logic                             accepted,
  output logic                             frame_done,
  input  logic                             cfg_we,
  input  logic [imtx_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [imtx_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import imtx_pkg::*;

  localparam int BIT_W = $clog2(DATA_WIDTH);
  localparam logic [CMP_W-1:0] DW_CMP = CMP_W'(DATA_WIDTH);

  logic [CFG_DATA_W-1:0] leader_blocks;
  logic [CFG_DATA_W-1:0] data_length;

  logic [PHASE_W-1:0]    phase, phase_next;
  logic [BC_W-1:0]       block_count, block_count_next;
  logic [BIT_W-1:0]      bit_index, bit_index_next;
  logic [DATA_WIDTH-1:0] shift_word, shift_word_next;
  logic                  even_ones, even_ones_next;
  logic                  sending, sending_next;
  logic                  carrier, carrier_next;
  logic                  accepted_next, done_next;

  logic                  take;
  logic [CFG_DATA_W-1:0] leader_len;
  logic [BC_W-1:0]       on_blocks;
  logic                  cur_bit;
  logic [BIT_W:0]        next_idx;
  logic [CMP_W-1:0]      dlen_ext, dlen_eff;

  assign in_ready   = !out_valid || out_ready;
  assign take       = in_valid && in_ready;
  assign carrier_on = carrier;
  assign busy_res   = sending;

  always_ff @(posedge clk) begin
    if (rst) begin
      leader_blocks <= LEADER_RESET;
      data_length   <= DLEN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LEADER_BLOCKS: leader_blocks <= cfg_data;
        REG_DATA_LENGTH:   data_length   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign leader_len = (leader_blocks > LEADER_MAX) ? LEADER_MAX : leader_blocks;
  assign on_blocks  = {div3(leader_len + 5'd1), 1'b0};
  assign cur_bit    = shift_word[bit_index];
  assign next_idx   = {1'b0, bit_index} + {{BIT_W{1'b0}}, 1'b1};
  assign dlen_ext   = CMP_W'(data_length);
  assign dlen_eff   = (dlen_ext > DW_CMP) ? DW_CMP : dlen_ext;

  always_comb begin
    phase_next       = phase;
    block_count_next = block_count;
    bit_index_next   = bit_index;
    shift_word_next  = shift_word;
    even_ones_next   = even_ones;
    sending_next     = sending;
    carrier_next     = carrier;
    accepted_next    = 1'b0;
    done_next        = 1'b0;

    if (action) begin
      if (!sending) begin
        shift_word_next  = data_word;
        even_ones_next   = ~^data_word;
        phase_next       = PH_LEADER;
        bit_index_next   = '0;
        block_count_next = '0;
        sending_next     = 1'b1;
        carrier_next     = 1'b1;
        accepted_next    = 1'b1;
      end
    end else if (sending) begin
      // count advances unless the part ends below
      block_count_next = block_count + 5'd1;
      unique case (phase)
        PH_LEADER: begin
          if (block_count < on_blocks) begin
            carrier_next = 1'b1;
          end else if (block_count <= leader_len) begin
            carrier_next = 1'b0;
          end else begin
            block_count_next = '0;
            phase_next       = PH_START;
          end
        end
        PH_START: begin
          if (block_count == 5'd0) begin
            carrier_next = 1'b1;
          end else if (block_count == 5'd1) begin
            carrier_next = 1'b0;
          end else begin
            block_count_next = '0;
            phase_next       = PH_DATA;
          end
        end
        PH_DATA: begin
          if (block_count == 5'd0) begin
            carrier_next = cur_bit;
          end else if (block_count == 5'd1) begin
            carrier_next = ~cur_bit;
          end else begin
            block_count_next = '0;
            // zero length still sends one bit
            if (CMP_W'(next_idx) >= dlen_eff) begin
              bit_index_next = '0;
              phase_next     = PH_PARITY;
            end else begin
              bit_index_next = next_idx[BIT_W-1:0];
            end
          end
        end
        PH_PARITY: begin
          if (block_count < PARITY_HALF) begin
            carrier_next = even_ones;
          end else if (block_count < PARITY_END) begin
            carrier_next = ~even_ones;
          end else begin
            block_count_next = '0;
            phase_next       = PH_LEADER;
            sending_next     = 1'b0;
            carrier_next     = 1'b0;
            shift_word_next  = '0;
            done_next        = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_LEADER;
      block_count <= '0;
      bit_index   <= '0;
      shift_word  <= '0;
      even_ones   <= 1'b0;
      sending     <= 1'b0;
      carrier     <= 1'b0;
      out_valid   <= 1'b0;
      accepted    <= 1'b0;
      frame_done  <= 1'b0;
    end else begin
      if (take) begin
        phase       <= phase_next;
        block_count <= block_count_next;
        bit_index   <= bit_index_next;
        shift_word  <= shift_word_next;
        even_ones   <= even_ones_next;
        sending     <= sending_next;
        carrier     <= carrier_next;
        accepted    <= accepted_next;
        frame_done  <= done_next;
        out_valid   <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `IMTX_ASSERT_IMPLY(a_start_keys_on, clk, rst, out_valid && accepted, carrier_on && busy_res)
  `IMTX_ASSERT_IMPLY(a_done_goes_idle, clk, rst, out_valid && frame_done, !carrier_on && !busy_res)
  `IMTX_ASSERT_IMPLY(a_idle_quiet, clk, rst, !sending, !carrier && phase == PH_LEADER && block_count == '0)
  `IMTX_ASSERT_NEXT(a_stall_holds, clk, rst, out_valid && !out_ready, out_valid && $stable(carrier) && $stable(sending))

endmodule
